@@ design/dpps_pkg.sv @@
package dpps_pkg;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  localparam logic [4:0] OFF_PCM_CTRL = 5'h10;
  localparam logic [4:0] OFF_PCM_RAW  = 5'h11;
  localparam logic [4:0] OFF_ENABLE   = 5'h15;

  localparam logic [1:0] SUB_VOL_DUTY = 2'd0;
  localparam logic [1:0] SUB_PER_LO   = 2'd2;
  localparam logic [1:0] SUB_PER_HI   = 2'd3;

  localparam logic [10:0] MIN_PERIOD   = 11'd7;
  localparam int unsigned PCM_MUTE_BIT = 6;

  typedef struct packed {
    logic       tick;
    logic       wr;
    logic [1:0] sub;
    logic       en_wr;
    logic       en_bit;
    logic [7:0] data;
  } chan_ctl_t;

  function automatic logic [2:0] duty_width(input logic [1:0] sel);
    logic [2:0] w;
    case (sel)
      2'd0:    w = 3'd1;
      2'd1:    w = 3'd2;
      2'd2:    w = 3'd4;
      default: w = 3'd6;
    endcase
    return w;
  endfunction

endpackage

@@ design/dpps_pulse.sv @@
module dpps_pulse (
  input  logic                clk,
  input  logic                rst_n,
  input  dpps_pkg::chan_ctl_t ctl,
  output logic [3:0]          level
);

  logic [3:0]  vol_r, vol_nxt;
  logic [1:0]  duty_r, duty_nxt;
  logic [10:0] period_r, period_nxt;
  logic        en_r, en_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [12:0] timer_r, timer_nxt;
  logic        active;
  logic [11:0] per_inc;

  always_comb begin
    vol_nxt    = vol_r;
    duty_nxt   = duty_r;
    period_nxt = period_r;
    en_nxt     = en_r;
    if (ctl.wr) begin
      case (ctl.sub)
        dpps_pkg::SUB_VOL_DUTY: begin
          vol_nxt  = ctl.data[3:0];
          duty_nxt = ctl.data[7:6];
        end
        dpps_pkg::SUB_PER_LO: period_nxt[7:0]  = ctl.data;
        dpps_pkg::SUB_PER_HI: period_nxt[10:8] = ctl.data[2:0];
        default: ;
      endcase
    end
    if (ctl.en_wr) begin
      en_nxt = ctl.en_bit;
    end
  end

  assign active  = en_nxt && (period_nxt >= dpps_pkg::MIN_PERIOD);
  assign per_inc = {1'b0, period_nxt} + 12'd1;
  assign level   = (active && (step_r < dpps_pkg::duty_width(duty_nxt))) ? vol_nxt : 4'd0;

  always_comb begin
    step_nxt  = step_r;
    timer_nxt = timer_r;
    if (ctl.tick && active) begin
      if (timer_r <= 13'd1) begin
        timer_nxt = {per_inc, 1'b0};
        step_nxt  = step_r + 3'd1;
      end else begin
        timer_nxt = timer_r - 13'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_r    <= '0;
      duty_r   <= '0;
      period_r <= '0;
      en_r     <= 1'b0;
      step_r   <= '0;
      timer_r  <= '0;
    end else begin
      vol_r    <= vol_nxt;
      duty_r   <= duty_nxt;
      period_r <= period_nxt;
      en_r     <= en_nxt;
      step_r   <= step_nxt;
      timer_r  <= timer_nxt;
    end
  end

endmodule

@@ design/dual_pulse_pcm_sound_unit_top.sv @@
// Channel | Ports                                            | Handshake
// in      | in_action, in_reg_offset, in_write_data          | in_valid / in_stall
// out     | out_pulse_a_level, out_pulse_b_level, out_pcm_level | out_valid / out_stall
//
// One transaction per cycle sustained unless out_stall holds the result register.
// Stage 1 registers the transaction, stage 2 updates channel state and the result register.
// Synchronous active-low reset clears all channel state and both valid flags.
// in_stall rises only when stage 1 is full and the result register is held by out_stall.
module dual_pulse_pcm_sound_unit_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_action,
  input  logic [4:0] in_reg_offset,
  input  logic [7:0] in_write_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_pulse_a_level,
  output logic [3:0] out_pulse_b_level,
  output logic [7:0] out_pcm_level
);

  logic       stage_vld_r;
  logic       act_r;
  logic [4:0] off_r;
  logic [7:0] data_r;

  logic       out_valid_r;
  logic [3:0] pa_r, pb_r;
  logic [7:0] pcm_r;

  logic [7:0] pcm_ctrl_r, pcm_ctrl_nxt;
  logic [7:0] pcm_raw_r, pcm_raw_nxt;

  logic       advance, fire, is_wr, pulse_wr;
  logic [3:0] lvl_a, lvl_b;
  logic [7:0] pcm_lvl;

  dpps_pkg::chan_ctl_t ctl_a, ctl_b;

  assign advance  = !out_valid_r || !out_stall;
  assign fire     = stage_vld_r && advance;
  assign in_stall = stage_vld_r && !advance;
  assign is_wr    = fire && (act_r == dpps_pkg::ACT_WRITE);
  assign pulse_wr = is_wr && (off_r[4:3] == 2'b00);

  always_comb begin
    ctl_a.tick   = fire && (act_r == dpps_pkg::ACT_TICK);
    ctl_a.wr     = pulse_wr && !off_r[2];
    ctl_a.sub    = off_r[1:0];
    ctl_a.en_wr  = is_wr && (off_r == dpps_pkg::OFF_ENABLE);
    ctl_a.en_bit = data_r[0];
    ctl_a.data   = data_r;
    ctl_b        = ctl_a;
    ctl_b.wr     = pulse_wr && off_r[2];
    ctl_b.en_bit = data_r[1];
  end

  dpps_pulse u_pulse_a (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl_a),
    .level (lvl_a)
  );

  dpps_pulse u_pulse_b (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl_b),
    .level (lvl_b)
  );

  always_comb begin
    pcm_ctrl_nxt = pcm_ctrl_r;
    pcm_raw_nxt  = pcm_raw_r;
    if (is_wr && (off_r == dpps_pkg::OFF_PCM_CTRL)) begin
      pcm_ctrl_nxt = data_r;
    end
    if (is_wr && (off_r == dpps_pkg::OFF_PCM_RAW)) begin
      pcm_raw_nxt = data_r;
    end
  end

  assign pcm_lvl = pcm_ctrl_nxt[dpps_pkg::PCM_MUTE_BIT] ? 8'd0 : pcm_raw_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
      pcm_ctrl_r  <= '0;
      pcm_raw_r   <= '0;
    end else begin
      if (!stage_vld_r || advance) begin
        stage_vld_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= stage_vld_r;
      end
      pcm_ctrl_r <= pcm_ctrl_nxt;
      pcm_raw_r  <= pcm_raw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      act_r  <= in_action;
      off_r  <= in_reg_offset;
      data_r <= in_write_data;
    end
    if (fire) begin
      pa_r  <= lvl_a;
      pb_r  <= lvl_b;
      pcm_r <= pcm_lvl;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pulse_a_level = pa_r;
  assign out_pulse_b_level = pb_r;
  assign out_pcm_level     = pcm_r;

  a_fire_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("stage 1 transaction did not reach the result register");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (stage_vld_r && out_valid_r))
    else $error("input stalled with room in the pipeline");

  a_drain_empties_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !stage_vld_r) |=> !out_valid_r)
    else $error("result repeated after it was taken");

endmodule
